### src/racw_pkg.sv
package racw_pkg;

   localparam int DEF_MAX_DEPTH   = 8;
   localparam int DEF_MAX_STREAMS = 256;

   localparam int POS_W = 33;
   localparam int EXT_W = 35;

   localparam logic [31:0] FCC_RIFF = 32'h4646_4952;
   localparam logic [31:0] FCC_AVI  = 32'h2049_5641;
   localparam logic [31:0] FCC_LIST = 32'h5453_494C;
   localparam logic [31:0] FCC_STRH = 32'h6872_7473;
   localparam logic [31:0] FCC_STRF = 32'h6672_7473;
   localparam logic [31:0] FCC_VIDS = 32'h7364_6976;
   localparam logic [31:0] FCC_AUDS = 32'h7364_7561;
   localparam logic [31:0] FCC_TXTS = 32'h7374_7874;
   localparam logic [31:0] FCC_SUBS = 32'h7362_7573;

   localparam int VID_FMT_MIN = 40;
   localparam int AUD_FMT_MIN = 16;
   localparam int STRH_LEN    = 8;
   localparam int VID_LEN     = 20;
   localparam int AUD_LEN     = 16;
   localparam int FILE_HDR    = 12;

   typedef enum logic [2:0] {
      PH_FILE, PH_SEEK, PH_HDR, PH_LTYPE, PH_DATA, PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      SK_NONE, SK_VIDEO, SK_AUDIO, SK_SUB, SK_OTHER
   } skind_type;

   typedef enum logic [1:0] {
      DK_STRH, DK_VIDEO, DK_AUDIO
   } dkind_type;

   typedef enum logic [3:0] {
      EV_ROOT        = 4'd0,
      EV_LIST        = 4'd1,
      EV_LEAF        = 4'd2,
      EV_STRH_VIDEO  = 4'd3,
      EV_STRH_AUDIO  = 4'd4,
      EV_STRH_SUB    = 4'd5,
      EV_STRH_OTHER  = 4'd6,
      EV_STRF_VIDEO  = 4'd7,
      EV_STRF_AUDIO  = 4'd8,
      EV_STRF_PLAIN  = 4'd9,
      EV_ERROR       = 4'd10
   } ev_type;

   typedef struct packed {
      logic [3:0]       event_kind;
      logic [31:0]      chunk_code;
      logic [31:0]      sub_code;
      logic [31:0]      chunk_length;
      logic [POS_W-1:0] chunk_position;
      logic [3:0]       nest_level;
      logic [7:0]       stream_number;
      logic [31:0]      field_a;
      logic [31:0]      field_b;
      logic [15:0]      field_c;
      logic [15:0]      channel_count;
   } rsp_type;

endpackage

### src/riff_avi_chunk_walker_top.sv
// Each event is registered into out_ff, or into skid_ff while the output holds.
// Throughput: one byte per cycle while req_stall is low; walk state moves per byte.
// A two-entry output buffer keeps bytes flowing while one event waits on rsp_stall.
// Reset (synchronous, active high) returns to file header check at byte 0,
// clears the level stream kinds, stream count and file_length.
module riff_avi_chunk_walker_top #(
   parameter int MAX_DEPTH   = racw_pkg::DEF_MAX_DEPTH,
   parameter int MAX_STREAMS = racw_pkg::DEF_MAX_STREAMS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_data_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [3:0]                  rsp_event_kind,
   output logic [31:0]                 rsp_chunk_code,
   output logic [31:0]                 rsp_sub_code,
   output logic [31:0]                 rsp_chunk_length,
   output logic [racw_pkg::POS_W-1:0]  rsp_chunk_position,
   output logic [3:0]                  rsp_nest_level,
   output logic [7:0]                  rsp_stream_number,
   output logic [31:0]                 rsp_field_a,
   output logic [31:0]                 rsp_field_b,
   output logic [15:0]                 rsp_field_c,
   output logic [15:0]                 rsp_channel_count,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [racw_pkg::POS_W-1:0]  csr_file_length
);

   logic [racw_pkg::POS_W-1:0] flen_ff;
   logic take, core_valid, pop;
   racw_pkg::rsp_type core_res, out_ff, skid_ff;
   logic out_valid_ff, skid_valid_ff;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign take      = req_valid && !req_stall;
   assign pop       = out_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) flen_ff <= '0;
      else if (csr_valid && csr_ready) flen_ff <= csr_file_length;
   end

   racw_walk #(
      .MAX_DEPTH   (MAX_DEPTH),
      .MAX_STREAMS (MAX_STREAMS)
   ) u_walk (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .data_byte   (req_data_byte),
      .file_length (flen_ff),
      .res_valid   (core_valid),
      .res         (core_res)
   );

   // refill from skid first, park a new word in skid while the output holds
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || pop) begin
         out_valid_ff  <= skid_valid_ff || core_valid;
         skid_valid_ff <= 1'b0;
      end else if (core_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || pop) begin
         out_ff <= skid_valid_ff ? skid_ff : core_res;
      end else if (core_valid) begin
         skid_ff <= core_res;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_event_kind     = out_ff.event_kind;
   assign rsp_chunk_code     = out_ff.chunk_code;
   assign rsp_sub_code       = out_ff.sub_code;
   assign rsp_chunk_length   = out_ff.chunk_length;
   assign rsp_chunk_position = out_ff.chunk_position;
   assign rsp_nest_level     = out_ff.nest_level;
   assign rsp_stream_number  = out_ff.stream_number;
   assign rsp_field_a        = out_ff.field_a;
   assign rsp_field_b        = out_ff.field_b;
   assign rsp_field_c        = out_ff.field_c;
   assign rsp_channel_count  = out_ff.channel_count;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff) else $error("skid holds a word with output empty");

   a_event_needs_byte: assert property (@(posedge clock) disable iff (reset)
      core_valid |-> take) else $error("event raised without an accepted byte");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_stall) |=> (rsp_valid && !skid_valid_ff))
      else $error("skid word lost on drain");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_event_kind <= racw_pkg::EV_ERROR) else $error("bad event kind");

endmodule

### src/racw_walk.sv
module racw_walk #(
   parameter int MAX_DEPTH   = racw_pkg::DEF_MAX_DEPTH,
   parameter int MAX_STREAMS = racw_pkg::DEF_MAX_STREAMS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         take,
   input  logic [7:0]                   data_byte,
   input  logic [racw_pkg::POS_W-1:0]   file_length,
   output logic                         res_valid,
   output racw_pkg::rsp_type            res
);

   localparam int LW  = $clog2(MAX_DEPTH + 1);
   localparam int CAP = (MAX_STREAMS - 1 < 255) ? MAX_STREAMS - 1 : 255;
   localparam int PW  = racw_pkg::POS_W;
   localparam int XW  = racw_pkg::EXT_W;

   racw_pkg::phase_type phase_ff, phase_in;
   racw_pkg::dkind_type dkind_ff, dkind_in;
   logic [PW-1:0]  pos_ff;
   logic [4:0]     got_ff, got_in, got_inc;
   logic [7:0]     hdr_ff [0:11];
   logic [7:0]     hdr_now [0:11];
   logic [7:0]     fmt_ff [0:19];
   logic [7:0]     fmt_now [0:19];
   logic [LW-1:0]  lvl_ff, lvl_in;
   logic [PW-1:0]  off_ff, off_in;
   logic [PW-1:0]  after_ff, after_in;
   logic [XW-1:0]  skip_ff, skip_in;
   logic [7:0]     total_ff, total_in;

   logic [PW-1:0]       end_ff [0:MAX_DEPTH];
   logic [PW-1:0]       resume_ff [0:MAX_DEPTH];
   logic [MAX_DEPTH:0]  rok_ff;
   racw_pkg::skind_type kind_ff [0:MAX_DEPTH];
   logic [7:0]          sidx_ff [0:MAX_DEPTH];

   // level writes
   logic                push_en, sk_en;
   logic [LW-1:0]       push_idx;
   logic [PW-1:0]       push_end, push_res;
   logic                push_rok;
   racw_pkg::skind_type sk_val;

   // end-of-list scan
   logic [MAX_DEPTH:0] hit, fwd;
   logic [LW-1:0]      chk_lv;
   logic               chk_found, chk_stop, chk_fwd;
   logic [PW-1:0]      chk_tgt;

   logic [31:0] code_now, size_now, type_now;
   logic [XW-1:0] fl_x, body, next_end, raw_end, expected, q_x;
   logic [PW-1:0] after_now;
   logic is_list, list_cut, strh_ok, vid_ok, aud_ok, lt_ok, deep, file_bad;
   logic file_end, hdr_end, lt_end, dat_end, seek_go;
   logic [4:0] need;
   racw_pkg::skind_type sk_cur, sk_new;
   logic [31:0] f_type, f_rate, f_avg, height;
   racw_pkg::ev_type strh_ev;

   assign got_inc = got_ff + 5'd1;

   always_comb begin
      hdr_now = hdr_ff;
      if ((phase_ff == racw_pkg::PH_FILE || phase_ff == racw_pkg::PH_HDR ||
           phase_ff == racw_pkg::PH_LTYPE) && got_ff < 5'd12) begin
         hdr_now[got_ff[3:0]] = data_byte;
      end else if (phase_ff == racw_pkg::PH_SEEK && seek_go && chk_found) begin
         hdr_now[0] = data_byte;
      end
   end

   always_comb begin
      fmt_now = fmt_ff;
      if (phase_ff == racw_pkg::PH_DATA && got_ff < 5'd20) begin
         fmt_now[got_ff] = data_byte;
      end
   end

   assign code_now = {hdr_now[3], hdr_now[2], hdr_now[1], hdr_now[0]};
   assign size_now = {hdr_now[7], hdr_now[6], hdr_now[5], hdr_now[4]};
   assign type_now = {hdr_now[11], hdr_now[10], hdr_now[9], hdr_now[8]};

   assign fl_x      = XW'(file_length);
   assign body      = XW'(off_ff) + XW'(8);
   assign next_end  = body + XW'(size_now) + XW'(size_now[0]);
   assign after_now = (next_end < fl_x) ? next_end[PW-1:0] : file_length;
   assign raw_end   = body + XW'(size_now);
   assign expected  = raw_end + XW'(size_now[0]);
   assign q_x       = XW'(off_ff) + XW'(12);
   assign lt_ok     = expected <= fl_x;
   assign deep      = lvl_ff == LW'(MAX_DEPTH);

   assign is_list  = code_now == racw_pkg::FCC_LIST || code_now == racw_pkg::FCC_RIFF;
   assign list_cut = body + XW'(4) > fl_x;
   assign strh_ok  = size_now >= 32'(racw_pkg::STRH_LEN) && fl_x >= body + XW'(racw_pkg::STRH_LEN);
   assign vid_ok   = size_now >= 32'(racw_pkg::VID_FMT_MIN) &&
                     fl_x >= body + XW'(racw_pkg::VID_FMT_MIN);
   assign aud_ok   = size_now >= 32'(racw_pkg::AUD_FMT_MIN) &&
                     fl_x >= body + XW'(racw_pkg::AUD_FMT_MIN);
   assign sk_cur   = kind_ff[lvl_ff];

   assign file_bad = code_now != racw_pkg::FCC_RIFF || type_now != racw_pkg::FCC_AVI ||
                     file_length < PW'(racw_pkg::FILE_HDR);

   always_comb begin
      case (dkind_ff)
         racw_pkg::DK_STRH:  need = 5'(racw_pkg::STRH_LEN);
         racw_pkg::DK_VIDEO: need = 5'(racw_pkg::VID_LEN);
         default:            need = 5'(racw_pkg::AUD_LEN);
      endcase
   end

   assign file_end = phase_ff == racw_pkg::PH_FILE  && got_inc == 5'd12;
   assign hdr_end  = phase_ff == racw_pkg::PH_HDR   && got_inc == 5'd8;
   assign lt_end   = phase_ff == racw_pkg::PH_LTYPE && got_inc == 5'd12;
   assign dat_end  = phase_ff == racw_pkg::PH_DATA  && got_inc == need;
   assign seek_go  = phase_ff == racw_pkg::PH_SEEK  && XW'(pos_ff) >= skip_ff;

   // per-level compares in parallel, then a narrow walk down the levels
   always_comb begin
      for (int i = 0; i <= MAX_DEPTH; i++) begin
         hit[i] = (XW'(pos_ff) + XW'(8)) >= XW'(end_ff[i]);
         fwd[i] = rok_ff[i] && resume_ff[i] > pos_ff;
      end
   end

   always_comb begin
      chk_lv    = lvl_ff;
      chk_found = 1'b0;
      chk_stop  = 1'b0;
      chk_fwd   = 1'b0;
      chk_tgt   = resume_ff[0];
      for (int s = 0; s <= MAX_DEPTH; s++) begin
         if (!chk_found && !chk_stop && !chk_fwd) begin
            if (chk_lv == '0 || chk_lv > LW'(MAX_DEPTH)) begin
               chk_stop = 1'b1;
               chk_lv   = '0;
            end else if (!hit[chk_lv]) begin
               chk_found = 1'b1;
            end else if (chk_lv == LW'(1)) begin
               chk_stop = 1'b1;
               chk_lv   = '0;
            end else begin
               if (fwd[chk_lv]) begin
                  chk_fwd = 1'b1;
                  chk_tgt = resume_ff[chk_lv];
               end
               chk_lv = chk_lv - LW'(1);
            end
         end
      end
   end

   always_comb begin
      f_type = {fmt_now[3], fmt_now[2], fmt_now[1], fmt_now[0]};
      if (f_type == racw_pkg::FCC_VIDS) begin
         strh_ev = racw_pkg::EV_STRH_VIDEO;
         sk_new  = racw_pkg::SK_VIDEO;
      end else if (f_type == racw_pkg::FCC_AUDS) begin
         strh_ev = racw_pkg::EV_STRH_AUDIO;
         sk_new  = racw_pkg::SK_AUDIO;
      end else if (f_type == racw_pkg::FCC_TXTS || f_type == racw_pkg::FCC_SUBS) begin
         strh_ev = racw_pkg::EV_STRH_SUB;
         sk_new  = racw_pkg::SK_SUB;
      end else begin
         strh_ev = racw_pkg::EV_STRH_OTHER;
         sk_new  = racw_pkg::SK_OTHER;
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         racw_pkg::PH_FILE: begin
            if (file_end) phase_in = file_bad ? racw_pkg::PH_DONE : racw_pkg::PH_SEEK;
         end
         racw_pkg::PH_SEEK: begin
            if (seek_go) begin
               if (chk_found)     phase_in = racw_pkg::PH_HDR;
               else if (chk_stop) phase_in = racw_pkg::PH_DONE;
            end
         end
         racw_pkg::PH_HDR: begin
            if (hdr_end) begin
               if (is_list) begin
                  phase_in = list_cut ? racw_pkg::PH_DONE : racw_pkg::PH_LTYPE;
               end else if (code_now == racw_pkg::FCC_STRH && strh_ok) begin
                  phase_in = racw_pkg::PH_DATA;
               end else if (code_now == racw_pkg::FCC_STRF &&
                            ((sk_cur == racw_pkg::SK_VIDEO && vid_ok) ||
                             (sk_cur == racw_pkg::SK_AUDIO && aud_ok))) begin
                  phase_in = racw_pkg::PH_DATA;
               end else begin
                  phase_in = racw_pkg::PH_SEEK;
               end
            end
         end
         racw_pkg::PH_LTYPE: if (lt_end) phase_in = racw_pkg::PH_SEEK;
         racw_pkg::PH_DATA:  if (dat_end) phase_in = racw_pkg::PH_SEEK;
         default:            phase_in = phase_ff;
      endcase
   end

   // datapath next values
   always_comb begin
      got_in   = got_ff;
      lvl_in   = lvl_ff;
      off_in   = off_ff;
      after_in = after_ff;
      skip_in  = skip_ff;
      total_in = total_ff;
      dkind_in = dkind_ff;
      push_en  = 1'b0;
      push_idx = lvl_ff + LW'(1);
      push_end = (raw_end < fl_x) ? raw_end[PW-1:0] : file_length;
      push_res = expected[PW-1:0];
      push_rok = lt_ok;
      sk_en    = 1'b0;
      sk_val   = sk_new;
      case (phase_ff)
         racw_pkg::PH_FILE: begin
            got_in = got_inc;
            if (file_end) begin
               got_in = '0;
               if (!file_bad) begin
                  lvl_in   = LW'(1);
                  push_en  = 1'b1;
                  push_idx = LW'(1);
                  push_end = (XW'(size_now) + XW'(8) < fl_x) ?
                             PW'(XW'(size_now) + XW'(8)) : file_length;
                  push_rok = 1'b0;
                  skip_in  = XW'(racw_pkg::FILE_HDR);
               end
            end
         end
         racw_pkg::PH_SEEK: begin
            if (seek_go) begin
               lvl_in = chk_lv;
               if (chk_found) begin
                  off_in = pos_ff;
                  got_in = 5'd1;
               end else if (chk_fwd) begin
                  skip_in = XW'(chk_tgt);
               end
            end
         end
         racw_pkg::PH_HDR: begin
            got_in = got_inc;
            if (hdr_end) begin
               after_in = after_now;
               skip_in  = XW'(after_now);
               got_in   = (is_list) ? got_inc : 5'd0;
               if (code_now == racw_pkg::FCC_STRH) dkind_in = racw_pkg::DK_STRH;
               else if (sk_cur == racw_pkg::SK_VIDEO) dkind_in = racw_pkg::DK_VIDEO;
               else dkind_in = racw_pkg::DK_AUDIO;
            end
         end
         racw_pkg::PH_LTYPE: begin
            got_in = got_inc;
            if (lt_end) begin
               if (deep) begin
                  skip_in = (lt_ok && expected > q_x) ? expected : q_x;
               end else begin
                  lvl_in  = lvl_ff + LW'(1);
                  push_en = 1'b1;
                  skip_in = q_x;
               end
            end
         end
         racw_pkg::PH_DATA: begin
            got_in = got_inc;
            if (dat_end) begin
               skip_in = XW'(after_ff);
               if (dkind_ff == racw_pkg::DK_STRH) begin
                  sk_en = 1'b1;
                  if (total_ff < 8'(CAP)) total_in = total_ff + 8'd1;
               end
            end
         end
         default: got_in = got_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= racw_pkg::PH_FILE;
         pos_ff   <= '0;
         got_ff   <= '0;
         lvl_ff   <= '0;
         skip_ff  <= '0;
         total_ff <= '0;
         rok_ff   <= '0;
         dkind_ff <= racw_pkg::DK_STRH;
         for (int i = 0; i <= MAX_DEPTH; i++) kind_ff[i] <= racw_pkg::SK_NONE;
      end else if (take) begin
         phase_ff <= phase_in;
         if (pos_ff != '1) pos_ff <= pos_ff + PW'(1);
         got_ff   <= got_in;
         lvl_ff   <= lvl_in;
         skip_ff  <= skip_in;
         total_ff <= total_in;
         dkind_ff <= dkind_in;
         if (push_en) begin
            rok_ff[push_idx]  <= push_rok;
            kind_ff[push_idx] <= racw_pkg::SK_NONE;
         end
         if (sk_en) kind_ff[lvl_ff] <= sk_val;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         off_ff   <= off_in;
         after_ff <= after_in;
         hdr_ff   <= hdr_now;
         fmt_ff   <= fmt_now;
         if (push_en) begin
            end_ff[push_idx]    <= push_end;
            resume_ff[push_idx] <= push_res;
            sidx_ff[push_idx]   <= 8'd0;
         end
         if (sk_en) sidx_ff[lvl_ff] <= total_ff;
      end
   end

   assign f_rate = {fmt_now[7], fmt_now[6], fmt_now[5], fmt_now[4]};
   assign f_avg  = {fmt_now[11], fmt_now[10], fmt_now[9], fmt_now[8]};
   assign height = f_avg[31] ? (~f_avg + 32'd1) : f_avg;

   // result of this byte
   always_comb begin
      res_valid          = 1'b0;
      res                = '0;
      res.chunk_code     = code_now;
      res.chunk_length   = size_now;
      res.chunk_position = off_ff;
      res.nest_level     = 4'(lvl_ff);
      if (take) begin
         if (file_end) begin
            res_valid = 1'b1;
            if (file_bad) begin
               res            = '0;
               res.event_kind = racw_pkg::EV_ERROR;
            end else begin
               res.event_kind     = racw_pkg::EV_ROOT;
               res.chunk_code     = racw_pkg::FCC_RIFF;
               res.sub_code       = racw_pkg::FCC_AVI;
               res.chunk_position = '0;
               res.nest_level     = '0;
            end
         end else if (hdr_end) begin
            if (is_list) begin
               res_valid      = list_cut;
               res.event_kind = racw_pkg::EV_LIST;
            end else if (code_now == racw_pkg::FCC_STRH) begin
               res_valid      = !strh_ok;
               res.event_kind = racw_pkg::EV_LEAF;
            end else if (code_now == racw_pkg::FCC_STRF) begin
               res_valid = !((sk_cur == racw_pkg::SK_VIDEO && vid_ok) ||
                             (sk_cur == racw_pkg::SK_AUDIO && aud_ok));
               res.event_kind    = racw_pkg::EV_STRF_PLAIN;
               res.stream_number = (sk_cur != racw_pkg::SK_NONE) ? sidx_ff[lvl_ff] : 8'd0;
            end else begin
               res_valid      = 1'b1;
               res.event_kind = racw_pkg::EV_LEAF;
            end
         end else if (lt_end) begin
            res_valid      = 1'b1;
            res.event_kind = racw_pkg::EV_LIST;
            res.sub_code   = type_now;
         end else if (dat_end) begin
            res_valid = 1'b1;
            case (dkind_ff)
               racw_pkg::DK_STRH: begin
                  res.event_kind    = strh_ev;
                  res.sub_code      = f_rate;
                  res.stream_number = total_ff;
               end
               racw_pkg::DK_VIDEO: begin
                  res.event_kind    = racw_pkg::EV_STRF_VIDEO;
                  res.sub_code      = {fmt_now[19], fmt_now[18], fmt_now[17], fmt_now[16]};
                  res.stream_number = sidx_ff[lvl_ff];
                  res.field_a       = f_rate;
                  res.field_b       = height;
                  res.field_c       = {fmt_now[15], fmt_now[14]};
               end
               default: begin
                  res.event_kind    = racw_pkg::EV_STRF_AUDIO;
                  res.sub_code      = {16'd0, fmt_now[1], fmt_now[0]};
                  res.stream_number = sidx_ff[lvl_ff];
                  res.field_a       = f_rate;
                  res.field_b       = f_avg;
                  res.field_c       = {fmt_now[15], fmt_now[14]};
                  res.channel_count = {fmt_now[3], fmt_now[2]};
               end
            endcase
         end
      end
   end

endmodule
